// ===== rtl/avg_pkg.sv =====
// Shared constants, types and the arctangent table of the arc vertex generator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package avg_pkg;

  localparam int unsigned SEGMENTS_DEF = 30;

  localparam int unsigned COORD_W     = 16;
  localparam int unsigned RAD_W       = 15;
  localparam int unsigned ANGLE_W     = 16;
  localparam int unsigned SWEEP_W     = 18;
  localparam int unsigned PHASE_SHIFT = 8;
  localparam int unsigned PHASE_W     = ANGLE_W + PHASE_SHIFT;
  localparam int unsigned DIV_W       = SWEEP_W + PHASE_SHIFT;
  localparam int unsigned ANG_W       = PHASE_W + 1;
  localparam int unsigned XY_W        = 32;
  localparam int unsigned PROD_W      = XY_W + RAD_W + 1;
  localparam int unsigned FRAC_W      = 30;

  localparam int unsigned CORDIC_ITERS = 18;
  localparam int unsigned ATAN_W       = 22;

  localparam logic signed [XY_W-1:0]    CORDIC_X0        = 32'sd652032874;
  localparam logic signed [PHASE_W-1:0] QUARTER_TURN     = 24'sd4194304;
  localparam logic signed [PHASE_W-1:0] NEG_QUARTER_TURN = -24'sd4194304;

  localparam logic [ATAN_W-1:0] ATAN_LUT [CORDIC_ITERS] = '{
    22'd2097152, 22'd1238021, 22'd654136, 22'd332050, 22'd166669, 22'd83416,
    22'd41718,   22'd20860,   22'd10430,  22'd5215,   22'd2608,   22'd1304,
    22'd652,     22'd326,     22'd163,    22'd81,     22'd41,     22'd20
  };

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ANG_W-1:0] a;
  } cord_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [RAD_W-1:0]          radius;
    logic                      last;
  } side_t;

endpackage

`default_nettype wire

// ===== rtl/arc_vertex_generator.sv =====
// Top level of the arc vertex generator: phase stepper, CORDIC cell chain, placement.
// Depends on avg_pkg, avg_phase_gen, avg_cordic_cell and avg_place.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid / in_stall  center_x, center_y, radius, start_angle,
//                                            sweep_angle
//   out_     output     out_valid/out_stall  vertex_x, vertex_y, last_vertex
//
// Each arc item yields SEGMENTS+1 vertices, one per cycle while the output is not
// stalled; the request buffer takes and divides the next item while one is stepped.
// The first vertex passes the divider, phase stepper, CORDIC cells and avg_place.
// Reset clears every valid flag and the request buffer; data registers are not reset.
// While out_stall holds a vertex, the pipeline from the phase stepper on holds;
// the request buffer may still take items and load one into an idle phase stepper.
`default_nettype none

module arc_vertex_generator #(
  parameter int unsigned SEGMENTS = avg_pkg::SEGMENTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [avg_pkg::COORD_W-1:0] in_center_x,
  input  logic signed [avg_pkg::COORD_W-1:0] in_center_y,
  input  logic [avg_pkg::RAD_W-1:0]          in_radius,
  input  logic [avg_pkg::ANGLE_W-1:0]        in_start_angle,
  input  logic signed [avg_pkg::SWEEP_W-1:0] in_sweep_angle,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [avg_pkg::COORD_W-1:0] out_vertex_x,
  output logic signed [avg_pkg::COORD_W-1:0] out_vertex_y,
  output logic                               out_last_vertex
);
  import avg_pkg::*;

  localparam logic signed [XY_W-1:0]  CORD_LIM     = 32'sd1073807360;
  localparam logic signed [XY_W-1:0]  NEG_CORD_LIM = -32'sd1073807360;
  localparam logic signed [ANG_W-1:0] QUARTER_EXT  = 25'sd4194304;
  localparam logic signed [ANG_W-1:0] NEG_QUARTER_EXT = -25'sd4194304;

  logic  adv;
  logic  vld_c  [CORDIC_ITERS+1];
  cord_t cord_c [CORDIC_ITERS+1];
  side_t side_c [CORDIC_ITERS+1];
  logic  mul_vld_r;
  logic  mul_last_r;
  logic  out_valid_r;
  logic  out_last_r;

  assign adv = !out_valid_r || !out_stall;

  avg_phase_gen #(
    .SEGMENTS(SEGMENTS)
  ) u_phase (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_center_x   (in_center_x),
    .in_center_y   (in_center_y),
    .in_radius     (in_radius),
    .in_start_angle(in_start_angle),
    .in_sweep_angle(in_sweep_angle),
    .en            (adv),
    .vld           (vld_c[0]),
    .cord          (cord_c[0]),
    .side          (side_c[0])
  );

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_cell
    avg_cordic_cell #(
      .STAGE(i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .in_vld  (vld_c[i]),
      .in_cord (cord_c[i]),
      .in_side (side_c[i]),
      .out_vld (vld_c[i+1]),
      .out_cord(cord_c[i+1]),
      .out_side(side_c[i+1])
    );
  end

  avg_place u_place_x (
    .clk   (clk),
    .en    (adv),
    .radius(side_c[CORDIC_ITERS].radius),
    .coord (cord_c[CORDIC_ITERS].x),
    .center(side_c[CORDIC_ITERS].cx),
    .vertex(out_vertex_x)
  );

  avg_place u_place_y (
    .clk   (clk),
    .en    (adv),
    .radius(side_c[CORDIC_ITERS].radius),
    .coord (cord_c[CORDIC_ITERS].y),
    .center(side_c[CORDIC_ITERS].cy),
    .vertex(out_vertex_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      mul_vld_r   <= vld_c[CORDIC_ITERS];
      out_valid_r <= mul_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mul_last_r <= side_c[CORDIC_ITERS].last;
      out_last_r <= mul_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_last_vertex = out_last_r;

  // A held output must freeze the head of the chain as well.
  a_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_c[0] && !adv) |=> (vld_c[0] && $stable(cord_c[0])))
    else $error("phase stage changed while the pipeline was held");

  a_folded_angle: assert property (@(posedge clk) disable iff (!rst_n)
    vld_c[0] |-> (cord_c[0].a <= QUARTER_EXT && cord_c[0].a >= NEG_QUARTER_EXT))
    else $error("start angle not folded into the right half plane");

  a_unit_gain_x: assert property (@(posedge clk) disable iff (!rst_n)
    vld_c[CORDIC_ITERS] |-> (cord_c[CORDIC_ITERS].x <= CORD_LIM
                             && cord_c[CORDIC_ITERS].x >= NEG_CORD_LIM))
    else $error("rotated x component exceeds unit magnitude");

  a_unit_gain_y: assert property (@(posedge clk) disable iff (!rst_n)
    vld_c[CORDIC_ITERS] |-> (cord_c[CORDIC_ITERS].y <= CORD_LIM
                             && cord_c[CORDIC_ITERS].y >= NEG_CORD_LIM))
    else $error("rotated y component exceeds unit magnitude");

endmodule

`default_nettype wire

// ===== rtl/avg_phase_gen.sv =====
// Request buffer, reciprocal divider and phase stepper of the arc vertex generator.
// Emits one folded CORDIC start vector per vertex; depends on avg_pkg.
`default_nettype none

module avg_phase_gen #(
  parameter int unsigned SEGMENTS = avg_pkg::SEGMENTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [avg_pkg::COORD_W-1:0] in_center_x,
  input  logic signed [avg_pkg::COORD_W-1:0] in_center_y,
  input  logic [avg_pkg::RAD_W-1:0]          in_radius,
  input  logic [avg_pkg::ANGLE_W-1:0]        in_start_angle,
  input  logic signed [avg_pkg::SWEEP_W-1:0] in_sweep_angle,
  input  logic                               en,
  output logic                               vld,
  output avg_pkg::cord_t                     cord,
  output avg_pkg::side_t                     side
);
  import avg_pkg::*;

  localparam int unsigned REM_W  = $clog2(SEGMENTS + 1);
  localparam int unsigned K_W    = $clog2(SEGMENTS + 1);
  localparam int unsigned DCNT_W = 2;
  localparam int unsigned RCP_SH = DIV_W + $clog2(SEGMENTS);
  localparam int unsigned RCP_W  = DIV_W + 2;
  localparam int unsigned MUL_W  = DIV_W + RCP_W;
  localparam longint unsigned RCP =
    ((64'd1 << RCP_SH) + 64'(SEGMENTS) - 64'd1) / 64'(SEGMENTS);
  localparam logic [RCP_W-1:0]  RCP_V    = RCP_W'(RCP);
  localparam logic [DIV_W-1:0]  SEG_D    = DIV_W'(SEGMENTS);
  localparam logic [REM_W:0]    SEG_V    = (REM_W + 1)'(SEGMENTS);
  localparam logic [REM_W-1:0]  HALF_SEG = REM_W'(SEGMENTS / 2);
  localparam logic [K_W-1:0]    LAST_K   = K_W'(SEGMENTS);
  localparam logic [DCNT_W-1:0] DIV_STEPS = 2'd2;
  localparam logic [DCNT_W-1:0] QUO_STEP  = 2'd2;
  localparam logic [DCNT_W-1:0] REM_STEP  = 2'd1;

  logic                      pend_full_r;
  logic [DCNT_W-1:0]         div_cnt_r;
  logic [DIV_W-1:0]          dq_r;
  logic [DIV_W-1:0]          quo_r;
  logic [REM_W-1:0]          rem_r;
  logic signed [COORD_W-1:0] p_cx_r;
  logic signed [COORD_W-1:0] p_cy_r;
  logic [RAD_W-1:0]          p_rad_r;
  logic [ANGLE_W-1:0]        p_start_r;
  logic                      p_neg_r;

  logic                      act_full_r;
  logic [K_W-1:0]            k_r;
  logic [PHASE_W-1:0]        q_r;
  logic [REM_W-1:0]          r_r;
  logic [PHASE_W-1:0]        qs_r;
  logic [REM_W-1:0]          rs_r;
  logic signed [COORD_W-1:0] a_cx_r;
  logic signed [COORD_W-1:0] a_cy_r;
  logic [RAD_W-1:0]          a_rad_r;
  logic [ANGLE_W-1:0]        a_start_r;
  logic                      a_neg_r;

  logic  vld_r;
  cord_t cord_r;
  side_t side_r;

  logic                      accept;
  logic                      div_done;
  logic                      fin;
  logic                      load;
  logic                      step;
  logic [SWEEP_W-1:0]        sweep_mag;
  logic [MUL_W-1:0]          mul;
  logic [DIV_W-1:0]          quo_nxt;
  logic [DIV_W-1:0]          rem_full;
  logic [REM_W:0]            acc;
  logic [REM_W:0]            acc_sub;
  logic                      carry;
  logic [REM_W-1:0]          r_nxt;
  logic [PHASE_W-1:0]        q_nxt;
  logic [PHASE_W-1:0]        start24;
  logic signed [PHASE_W-1:0] phase;
  logic                      fold;
  logic signed [PHASE_W-1:0] folded;

  assign accept   = in_valid && !pend_full_r;
  assign in_stall = pend_full_r;
  assign div_done = (div_cnt_r == '0);
  assign fin      = en && act_full_r && (k_r == LAST_K);
  assign load     = pend_full_r && div_done && (!act_full_r || fin);
  assign step     = en && act_full_r;

  always_comb begin
    sweep_mag = in_sweep_angle[SWEEP_W-1] ? -in_sweep_angle : in_sweep_angle;
    mul       = dq_r * RCP_V;
    quo_nxt   = DIV_W'(mul >> RCP_SH);
    rem_full  = dq_r - quo_r * SEG_D;
    acc       = {1'b0, r_r} + {1'b0, rs_r};
    carry     = (acc >= SEG_V);
    acc_sub   = acc - SEG_V;
    r_nxt     = carry ? acc_sub[REM_W-1:0] : acc[REM_W-1:0];
    q_nxt     = q_r + qs_r + PHASE_W'(carry);
    start24   = {a_start_r, {PHASE_SHIFT{1'b0}}};
    phase     = a_neg_r ? $signed(start24 - q_r) : $signed(start24 + q_r);
    fold      = (phase > QUARTER_TURN) || (phase < NEG_QUARTER_TURN);
    folded    = {phase[PHASE_W-1] ^ fold, phase[PHASE_W-2:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_full_r <= 1'b0;
      div_cnt_r   <= '0;
      act_full_r  <= 1'b0;
      k_r         <= '0;
      vld_r       <= 1'b0;
    end else begin
      if (accept) begin
        pend_full_r <= 1'b1;
        div_cnt_r   <= DIV_STEPS;
      end else begin
        if (load) begin
          pend_full_r <= 1'b0;
        end
        if (!div_done) begin
          div_cnt_r <= div_cnt_r - 1'b1;
        end
      end
      if (load) begin
        act_full_r <= 1'b1;
        k_r        <= '0;
      end else if (step) begin
        if (fin) begin
          act_full_r <= 1'b0;
        end
        k_r <= k_r + 1'b1;
      end
      if (en) begin
        vld_r <= act_full_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dq_r      <= {sweep_mag, {PHASE_SHIFT{1'b0}}};
      p_cx_r    <= in_center_x;
      p_cy_r    <= in_center_y;
      p_rad_r   <= in_radius;
      p_start_r <= in_start_angle;
      p_neg_r   <= in_sweep_angle[SWEEP_W-1];
    end else if (div_cnt_r == QUO_STEP) begin
      quo_r <= quo_nxt;
    end else if (div_cnt_r == REM_STEP) begin
      rem_r <= rem_full[REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q_r       <= '0;
      r_r       <= HALF_SEG;
      qs_r      <= quo_r[PHASE_W-1:0];
      rs_r      <= rem_r;
      a_cx_r    <= p_cx_r;
      a_cy_r    <= p_cy_r;
      a_rad_r   <= p_rad_r;
      a_start_r <= p_start_r;
      a_neg_r   <= p_neg_r;
    end else if (step) begin
      q_r <= q_nxt;
      r_r <= r_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cord_r.x      <= fold ? -CORDIC_X0 : CORDIC_X0;
      cord_r.y      <= '0;
      cord_r.a      <= {folded[PHASE_W-1], folded};
      side_r.cx     <= a_cx_r;
      side_r.cy     <= a_cy_r;
      side_r.radius <= a_rad_r;
      side_r.last   <= (k_r == LAST_K);
    end
  end

  assign vld  = vld_r;
  assign cord = cord_r;
  assign side = side_r;

endmodule

`default_nettype wire

// ===== rtl/avg_cordic_cell.sv =====
// One rotation-mode CORDIC iteration, registered, with the vertex data riding along.
// Chained CORDIC_ITERS times by the top level; depends on avg_pkg.
`default_nettype none

module avg_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  avg_pkg::cord_t in_cord,
  input  avg_pkg::side_t in_side,
  output logic           out_vld,
  output avg_pkg::cord_t out_cord,
  output avg_pkg::side_t out_side
);
  import avg_pkg::*;

  logic signed [XY_W-1:0]  xi;
  logic signed [XY_W-1:0]  yi;
  logic signed [ANG_W-1:0] ai;
  logic signed [XY_W-1:0]  dx;
  logic signed [XY_W-1:0]  dy;
  logic signed [ANG_W-1:0] ang_step;
  cord_t                   cord_nxt;
  logic                    vld_r;
  cord_t                   cord_r;
  side_t                   side_r;

  always_comb begin
    xi       = in_cord.x;
    yi       = in_cord.y;
    ai       = in_cord.a;
    dx       = yi >>> STAGE;
    dy       = xi >>> STAGE;
    ang_step = $signed({{(ANG_W - ATAN_W){1'b0}}, ATAN_LUT[STAGE]});
    if (!ai[ANG_W-1]) begin
      cord_nxt.x = xi - dx;
      cord_nxt.y = yi + dy;
      cord_nxt.a = ai - ang_step;
    end else begin
      cord_nxt.x = xi + dx;
      cord_nxt.y = yi - dy;
      cord_nxt.a = ai + ang_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cord_r <= cord_nxt;
      side_r <= in_side;
    end
  end

  assign out_vld  = vld_r;
  assign out_cord = cord_r;
  assign out_side = side_r;

endmodule

`default_nettype wire

// ===== rtl/avg_place.sv =====
// Scales one CORDIC component by the radius, rounds, adds the centre and saturates.
// Two register stages, instanced once per axis; depends on avg_pkg.
`default_nettype none

module avg_place (
  input  logic                               clk,
  input  logic                               en,
  input  logic [avg_pkg::RAD_W-1:0]          radius,
  input  logic signed [avg_pkg::XY_W-1:0]    coord,
  input  logic signed [avg_pkg::COORD_W-1:0] center,
  output logic signed [avg_pkg::COORD_W-1:0] vertex
);
  import avg_pkg::*;

  localparam int unsigned SH_W  = PROD_W - FRAC_W;
  localparam int unsigned SUM_W = SH_W + 1;
  localparam logic signed [PROD_W-1:0]  ROUND_HALF = PROD_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [SUM_W-1:0]   SAT_HI = SUM_W'(2 ** (COORD_W - 1) - 1);
  localparam logic signed [SUM_W-1:0]   SAT_LO = -SUM_W'(2 ** (COORD_W - 1));

  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [COORD_W-1:0] center_r;
  logic signed [PROD_W-1:0]  rounded;
  logic signed [SH_W-1:0]    scaled;
  logic signed [SUM_W-1:0]   sum;
  logic signed [COORD_W-1:0] vertex_nxt;
  logic signed [COORD_W-1:0] vertex_r;

  always_comb begin
    prod_nxt = $signed({1'b0, radius}) * coord;
    rounded  = prod_r + ROUND_HALF;
    scaled   = rounded[PROD_W-1:FRAC_W];
    sum      = {scaled[SH_W-1], scaled}
             + {{(SUM_W - COORD_W){center_r[COORD_W-1]}}, center_r};
    if (sum > SAT_HI) begin
      vertex_nxt = SAT_HI[COORD_W-1:0];
    end else if (sum < SAT_LO) begin
      vertex_nxt = SAT_LO[COORD_W-1:0];
    end else begin
      vertex_nxt = sum[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r   <= prod_nxt;
      center_r <= center;
      vertex_r <= vertex_nxt;
    end
  end

  assign vertex = vertex_r;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for arc_vertex_generator: a directed table and then random arcs,
// with each vertex checked against a pinned position or a CORDIC predictor in integers.
// Depends on avg_pkg and arc_vertex_generator.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import avg_pkg::*;

  localparam int     ARC_SEGS      = SEGMENTS_DEF;
  localparam int     RANDOM_ARCS   = 470;
  localparam int     DIRECTED_ROWS = 16;
  localparam int     ROT_STEPS     = 18;
  localparam longint TURN_HALF     = 64'sd8388608;
  localparam longint TURN_QUARTER  = 64'sd4194304;
  localparam longint UNIT_X0       = 64'sd652032874;
  localparam longint ARCTAN_STEPS [ROT_STEPS] = '{
    64'sd2097152, 64'sd1238021, 64'sd654136, 64'sd332050, 64'sd166669, 64'sd83416,
    64'sd41718,   64'sd20860,   64'sd10430,  64'sd5215,   64'sd2608,   64'sd1304,
    64'sd652,     64'sd326,     64'sd163,    64'sd81,     64'sd41,     64'sd20
  };

  typedef struct {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [RAD_W-1:0]          radius;
    logic [ANGLE_W-1:0]        start;
    logic signed [SWEEP_W-1:0] sweep;
  } arc_req_t;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
  } vertex_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [RAD_W-1:0]          radius;
    logic [ANGLE_W-1:0]        start;
    logic signed [SWEEP_W-1:0] sweep;
    logic                      pinned;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
  } arc_row_t;

  // Rows with pinned set carry their vertex position, which every vertex of the arc must hit.
  localparam arc_row_t ARC_TABLE [DIRECTED_ROWS] = '{
    '{16'sd0, 16'sd0, 15'd0, 16'd0, 18'sd0, 1'b1, 16'sd0, 16'sd0},
    '{16'h8000, 16'h7FFF, 15'd0, 16'hFFFF, 18'sd65536, 1'b1, 16'h8000, 16'h7FFF},
    '{16'h7FFF, 16'h7FFF, 15'h7FFF, 16'd0, 18'sd0, 1'b1, 16'h7FFF, 16'h7FFF},
    '{16'h8000, 16'h8000, 15'h7FFF, 16'h8000, 18'sd0, 1'b1, 16'h8000, 16'h8000},
    '{16'sd0, 16'sd0, 15'd1000, 16'd0, 18'sd65536, 1'b0, 16'sd0, 16'sd0},
    '{16'sd0, 16'sd0, 15'd1000, 16'd0, -18'sd65536, 1'b0, 16'sd0, 16'sd0},
    '{16'sd320, -16'sd480, 15'd4000, 16'hFFFF, 18'h1FFFF, 1'b0, 16'sd0, 16'sd0},
    '{-16'sd320, 16'sd480, 15'd4000, 16'd0, 18'h20000, 1'b0, 16'sd0, 16'sd0},
    '{16'sd1234, 16'sd4321, 15'd2500, 16'd12345, 18'sd0, 1'b0, 16'sd0, 16'sd0},
    '{16'sd0, 16'sd0, 15'h7FFF, 16'd100, 18'sd1, 1'b0, 16'sd0, 16'sd0},
    '{16'sd0, 16'sd0, 15'h7FFF, 16'd100, -18'sd1, 1'b0, 16'sd0, 16'sd0},
    '{16'sd800, 16'sd800, 15'd6000, 16'h4000, 18'sd32768, 1'b0, 16'sd0, 16'sd0},
    '{-16'sd800, -16'sd800, 15'd6000, 16'hC000, -18'sd32768, 1'b0, 16'sd0, 16'sd0},
    '{16'sd0, 16'sd0, 15'h7FFF, 16'h2000, 18'sd65536, 1'b0, 16'sd0, 16'sd0},
    '{16'sd20000, -16'sd20000, 15'h7FFF, 16'd0, 18'sd65536, 1'b0, 16'sd0, 16'sd0},
    '{-16'sd1, 16'sd1, 15'h5555, 16'h5555, 18'sd15, 1'b0, 16'sd0, 16'sd0}
  };

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [COORD_W-1:0] in_center_x;
  logic signed [COORD_W-1:0] in_center_y;
  logic [RAD_W-1:0]          in_radius;
  logic [ANGLE_W-1:0]        in_start_angle;
  logic signed [SWEEP_W-1:0] in_sweep_angle;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [COORD_W-1:0] out_vertex_x;
  logic signed [COORD_W-1:0] out_vertex_y;
  logic                      out_last_vertex;

  vertex_t pending_vertices [$];
  vertex_t want;
  int      mismatch_count;
  int      vertices_checked;
  int      arcs_accepted;
  bit      calm_phase;

  arc_vertex_generator uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_center_x     (in_center_x),
    .in_center_y     (in_center_y),
    .in_radius       (in_radius),
    .in_start_angle  (in_start_angle),
    .in_sweep_angle  (in_sweep_angle),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_vertex_x    (out_vertex_x),
    .out_vertex_y    (out_vertex_y),
    .out_last_vertex (out_last_vertex)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic void unit_rotate(input logic [PHASE_W-1:0] phase,
                                      output longint cos_q30, output longint sin_q30);
    longint a;
    longint x;
    longint y;
    longint dx;
    longint dy;
    a = longint'(phase);
    x = UNIT_X0;
    y = 64'sd0;
    if (a >= TURN_HALF) begin
      a = a - 2 * TURN_HALF;
    end
    if (a > TURN_QUARTER || a < -TURN_QUARTER) begin
      a = (a > 0) ? a - TURN_HALF : a + TURN_HALF;
      x = -x;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (a >= 0) begin
        x = x - dx;
        y = y + dy;
        a = a - ARCTAN_STEPS[i];
      end else begin
        x = x + dx;
        y = y - dy;
        a = a + ARCTAN_STEPS[i];
      end
    end
    cos_q30 = x;
    sin_q30 = y;
  endfunction

  function automatic logic signed [COORD_W-1:0] place_coord(input longint centre,
                                                            input longint rad,
                                                            input longint unit_q30);
    longint v;
    v = centre + ((rad * unit_q30 + (64'sd1 <<< 30) / 2) >>> 30);
    if (v > 64'sd32767) begin
      v = 64'sd32767;
    end
    if (v < -64'sd32768) begin
      v = -64'sd32768;
    end
    return v[COORD_W-1:0];
  endfunction

  // The phase of each vertex is taken from the request itself, rounded half away from zero.
  task automatic queue_arc_vertices(input arc_req_t req);
    longint num;
    longint mag;
    longint step;
    longint full_phase;
    longint cs;
    longint sn;
    vertex_t v;
    for (longint k = 0; k <= longint'(ARC_SEGS); k++) begin
      num = longint'(req.sweep) * k * 64'sd256;
      mag = (num < 0) ? -num : num;
      step = (mag + longint'(ARC_SEGS / 2)) / longint'(ARC_SEGS);
      if (num < 0) begin
        step = -step;
      end
      full_phase = longint'(req.start) * 64'sd256 + step;
      unit_rotate(full_phase[PHASE_W-1:0], cs, sn);
      v.x = place_coord(longint'(req.cx), longint'(req.radius), cs);
      v.y = place_coord(longint'(req.cy), longint'(req.radius), sn);
      v.last = (k == longint'(ARC_SEGS));
      pending_vertices.push_back(v);
    end
  endtask

  function automatic int pick_gap();
    int roll;
    roll = int'($urandom_range(99));
    if (calm_phase || roll < 55) begin
      return 0;
    end
    if (roll < 90) begin
      return int'($urandom_range(4, 1));
    end
    return int'($urandom_range(70, 20));
  endfunction

  function automatic int pick_hold();
    int roll;
    roll = int'($urandom_range(99));
    if (calm_phase || roll < 65) begin
      return 0;
    end
    if (roll < 95) begin
      return int'($urandom_range(3, 1));
    end
    return int'($urandom_range(16, 6));
  endfunction

  function automatic arc_req_t random_arc();
    arc_req_t req;
    int roll;
    int sw;
    req.cx = COORD_W'($urandom);
    req.cy = COORD_W'($urandom);
    req.radius = RAD_W'($urandom);
    req.start = ANGLE_W'($urandom);
    roll = int'($urandom_range(99));
    if (roll < 70) begin
      sw = int'($urandom_range(131072)) - 65536;
    end else if (roll < 85) begin
      sw = int'($urandom_range(200)) - 100;
    end else begin
      sw = int'($urandom_range(262143)) - 131072;
    end
    req.sweep = sw[SWEEP_W-1:0];
    roll = int'($urandom_range(99));
    if (roll < 8) begin
      req.radius = '0;
    end else if (roll < 16) begin
      req.radius = '1;
    end else if (roll < 40) begin
      req.radius = RAD_W'($urandom_range(2000));
    end
    return req;
  endfunction

  // Entered and left at a falling edge; the item is held until the block takes it.
  task automatic offer_arc(input arc_req_t req, input bit pinned,
                           input logic signed [COORD_W-1:0] px,
                           input logic signed [COORD_W-1:0] py);
    int gap;
    vertex_t v;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_center_x    <= req.cx;
    in_center_y    <= req.cy;
    in_radius      <= req.radius;
    in_start_angle <= req.start;
    in_sweep_angle <= req.sweep;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (pinned) begin
      for (int k = 0; k <= ARC_SEGS; k++) begin
        v.x = px;
        v.y = py;
        v.last = (k == ARC_SEGS);
        pending_vertices.push_back(v);
      end
    end else begin
      queue_arc_vertices(req);
    end
    arcs_accepted++;
    @(negedge clk);
  endtask

  initial begin
    int hold;
    out_stall = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
        hold = pick_hold();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_vertices.size() == 0) begin
        report_mismatch($sformatf("vertex (%0d, %0d) arrived with none outstanding",
                                  out_vertex_x, out_vertex_y));
      end else begin
        want = pending_vertices.pop_front();
        if (out_vertex_x !== want.x) begin
          report_mismatch($sformatf("vertex %0d x: got %0d, expected %0d",
                                    vertices_checked, out_vertex_x, want.x));
        end
        if (out_vertex_y !== want.y) begin
          report_mismatch($sformatf("vertex %0d y: got %0d, expected %0d",
                                    vertices_checked, out_vertex_y, want.y));
        end
        if (out_last_vertex !== want.last) begin
          report_mismatch($sformatf("vertex %0d last flag: got %b, expected %b",
                                    vertices_checked, out_last_vertex, want.last));
        end
        vertices_checked++;
      end
    end
  end

  initial begin
    arc_req_t req;
    arc_row_t row;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_center_x    = '0;
    in_center_y    = '0;
    in_radius      = '0;
    in_start_angle = '0;
    in_sweep_angle = '0;
    calm_phase     = 1'b0;
    mismatch_count = 0;
    vertices_checked = 0;
    arcs_accepted  = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      row = ARC_TABLE[r];
      req.cx = row.cx;
      req.cy = row.cy;
      req.radius = row.radius;
      req.start = row.start;
      req.sweep = row.sweep;
      offer_arc(req, row.pinned, row.px, row.py);
    end

    for (int n = 0; n < RANDOM_ARCS; n++) begin
      calm_phase = ((n / 50) % 4 == 2);
      // Let the block run completely dry before the random part and once halfway through.
      if (n == 0 || n == RANDOM_ARCS / 2) begin
        in_valid <= 1'b0;
        while (pending_vertices.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      offer_arc(random_arc(), 1'b0, '0, '0);
    end
    in_valid <= 1'b0;

    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Run covered %0d arcs, %0d of them from the directed table, and %0d vertices.",
             arcs_accepted, DIRECTED_ROWS, vertices_checked);
    $display("Sweeps ran both ways, past a full turn, with zero radius and saturating centres.");
    if (mismatch_count == 0) begin
      $display("arc_vertex_generator verification clean");
    end else begin
      $display("arc_vertex_generator verification failed");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("Timed out with %0d vertices still outstanding.", pending_vertices.size());
    $display("arc_vertex_generator verification failed");
    $finish;
  end

endmodule

`default_nettype wire
